>>> hdl/lla_pkg.sv
// Shared types, codes and constants for the life-like automaton generation block.
// Depends on nothing; imported by lla_row_update and the top level of the block.
package lla_pkg;

   // grid geometry
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + 1;

   // register and field widths
   localparam int MASK_W   = 9;
   localparam int SIZE_W   = 7;
   localparam int GEN_W    = 16;
   localparam int CNT_W    = 4;
   localparam int MASK_PAD_W = 2 ** CNT_W;

   // sweep sequencer: one row read per step, plus the wrap row and the last row
   localparam int STEP_LAST = MAX_ROWS + 2;
   localparam int STEP_W    = $clog2(STEP_LAST + 1);

   // register reset values (B3/S23 on the full grid)
   localparam logic [MASK_W-1:0] BIRTH_RESET   = MASK_W'(8);
   localparam logic [MASK_W-1:0] SURVIVE_RESET = MASK_W'(12);
   localparam logic [SIZE_W-1:0] SIZE_RESET    = SIZE_W'(64);

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_BIRTH_MASK   = 2'd0,
      CSR_SURVIVE_MASK = 2'd1,
      CSR_ROWS_IN_USE  = 2'd2,
      CSR_COLS_IN_USE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type             operation;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               cell_value;
      logic [GEN_W-1:0]   generation_count;
   } req_type;

   typedef struct packed {
      logic               read_value;
      logic [GEN_W-1:0]   generations_done;
   } rsp_type;

   // last row index in use: zero acts as one, oversize acts as the maximum
   function automatic logic [ROW_W-1:0] last_row_of(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return '0;
      end else if (v > SIZE_W'(MAX_ROWS)) begin
         return ROW_W'(MAX_ROWS - 1);
      end else begin
         return ROW_W'(v - SIZE_W'(1));
      end
   endfunction

   // last column index in use, same clamping
   function automatic logic [COL_W-1:0] last_col_of(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return '0;
      end else if (v > SIZE_W'(MAX_COLS)) begin
         return COL_W'(MAX_COLS - 1);
      end else begin
         return COL_W'(v - SIZE_W'(1));
      end
   endfunction

endpackage

>>> hdl/lla_grid_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Holds both grid banks; no package dependency.
module lla_grid_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lla_row_update.sv
// Next-generation logic for one grid row: one lane per column with wrapped neighbours.
// Depends on lla_pkg for widths.
module lla_row_update (
   input  logic [lla_pkg::MAX_COLS-1:0] up_row,
   input  logic [lla_pkg::MAX_COLS-1:0] mid_row,
   input  logic [lla_pkg::MAX_COLS-1:0] dn_row,
   input  logic [lla_pkg::COL_W-1:0]    last_col,
   input  logic [lla_pkg::MASK_W-1:0]   birth_mask,
   input  logic [lla_pkg::MASK_W-1:0]   survive_mask,
   output logic [lla_pkg::MAX_COLS-1:0] new_row
);
   import lla_pkg::*;

   logic [1:0] colsum [MAX_COLS];

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
      logic [1:0]            left_sum;
      logic [1:0]            right_sum;
      logic [CNT_W-1:0]      cnt;
      logic [MASK_PAD_W-1:0] mask;

      // vertical sum of the three rows in this column
      assign colsum[c] = {1'b0, up_row[c]} + {1'b0, mid_row[c]} + {1'b0, dn_row[c]};

      // left neighbour column, wrapping to the last column in use
      if (c == 0) begin : g_left_wrap
         assign left_sum = colsum[last_col];
      end else begin : g_left
         assign left_sum = colsum[c-1];
      end

      // right neighbour column, wrapping to column zero
      if (c == MAX_COLS - 1) begin : g_right_wrap
         assign right_sum = colsum[0];
      end else begin : g_right
         assign right_sum = (COL_W'(c) == last_col) ? colsum[0] : colsum[c+1];
      end

      // neighbour count excludes the cell itself
      assign cnt = {2'b00, left_sum} + {2'b00, colsum[c]} + {2'b00, right_sum}
                   - {{(CNT_W-1){1'b0}}, mid_row[c]};

      assign mask = mid_row[c] ? {{(MASK_PAD_W-MASK_W){1'b0}}, survive_mask}
                               : {{(MASK_PAD_W-MASK_W){1'b0}}, birth_mask};

      // columns beyond the area in use keep their value
      assign new_row[c] = (COL_W'(c) <= last_col) ? mask[cnt] : mid_row[c];
   end

endmodule

>>> hdl/life_like_automaton_generation.sv
// Top level of the life-like automaton generation block: control sequencer and registers.
// Depends on lla_pkg, lla_grid_ram and lla_row_update.
//
// Usage
//   Commands enter on req_data and are taken at a clock edge where start is high and
//   busy is low. Every command gives exactly one transaction on rsp_data, marked by a
//   one-cycle rsp_valid strobe; the receiver must take it in that cycle.
//   Configuration registers are written on the csr_ channel (csr_ready is always high)
//   and should only be written while no command is in flight.
// Response order
//   No operation, or advance by zero: strobe in the cycle after the command is taken.
//   Cell write or read: the strobe follows the ST_CELL state, with the row read back.
//   Advance by n: one generation sweeps all MAX_ROWS rows of the grid memory through a
//   single read port and a single write port; the strobe follows the final sweep step
//   of the last generation.
//   A new command may be taken in the same cycle as the strobe.
// Reset
//   Registers return to B3/S23 on a 64 x 64 torus and the generation count clears.
//   A clearing pass then writes the live grid bank dead, one row per cycle, over all
//   MAX_ROWS = 64 rows with busy high; configuration writes are taken meanwhile.
module life_like_automaton_generation (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lla_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output lla_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  lla_pkg::csr_index_type        csr_index,
   input  logic [lla_pkg::MASK_W-1:0]    csr_data
);
   import lla_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_GEN
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                bank_ff, bank_in;
   req_type             req_ff, req_in;
   logic                inside_ff, inside_in;
   logic [GEN_W-1:0]    remaining_ff, remaining_in;
   logic [GEN_W-1:0]    gen_count_ff, gen_count_in;
   logic [MAX_COLS-1:0] up_ff, up_in;
   logic [MAX_COLS-1:0] mid_ff, mid_in;
   logic [MAX_COLS-1:0] row0_ff, row0_in;
   logic [MASK_W-1:0]   birth_ff, birth_in;
   logic [MASK_W-1:0]   survive_ff, survive_in;
   logic [SIZE_W-1:0]   rows_ff, rows_in;
   logic [SIZE_W-1:0]   cols_ff, cols_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [ROW_W-1:0]    last_row;
   logic [COL_W-1:0]    last_col;
   logic [ROW_W-1:0]    rd_row;
   logic [ROW_W-1:0]    data_row;
   logic                data_step;
   logic                final_step;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [MAX_COLS-1:0] ram_wdata;
   logic [MAX_COLS-1:0] ram_rdata;
   logic [MAX_COLS-1:0] dn_row;
   logic [MAX_COLS-1:0] new_row;
   logic [MAX_COLS-1:0] cell_row;

   // effective grid size and sweep position
   assign last_row   = last_row_of(rows_ff);
   assign last_col   = last_col_of(cols_ff);
   assign rd_row     = (step_ff == '0) ? last_row : ROW_W'(step_ff - STEP_W'(1));
   assign data_row   = ROW_W'(step_ff - STEP_W'(2));
   assign data_step  = (step_ff >= STEP_W'(3)) && (step_ff <= STEP_W'(MAX_ROWS + 1));
   assign final_step = (step_ff == STEP_W'(STEP_LAST));
   assign dn_row     = final_step ? row0_ff : ram_rdata;

   // row with the addressed cell replaced, for a cell write
   always_comb begin
      cell_row               = ram_rdata;
      cell_row[req_ff.col]   = req_ff.cell_value;
   end

   // grid memory: two banks, live bank selected by bank_ff
   lla_grid_ram #(
      .DEPTH (2 * MAX_ROWS),
      .WIDTH (MAX_COLS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lla_row_update u_row_update (
      .up_row       (up_ff),
      .mid_row      (mid_ff),
      .dn_row       (dn_row),
      .last_col     (last_col),
      .birth_mask   (birth_ff),
      .survive_mask (survive_ff),
      .new_row      (new_row)
   );

   // memory port control
   always_comb begin
      ram_raddr = {bank_ff, req_data.row};
      ram_we    = 1'b0;
      ram_waddr = {bank_ff, req_ff.row};
      ram_wdata = cell_row;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = {1'b0, step_ff[ROW_W-1:0]};
            ram_wdata = '0;
         end
         ST_IDLE: begin
            ram_raddr = {bank_ff, req_data.row};
         end
         ST_CELL: begin
            ram_we = (req_ff.operation == OP_WRITE) && inside_ff;
         end
         ST_GEN: begin
            ram_raddr = {bank_ff, rd_row};
            if (data_step) begin
               ram_we = 1'b1;
               if (data_row <= last_row) begin
                  ram_waddr = {~bank_ff, ROW_W'(data_row - ROW_W'(1))};
                  ram_wdata = new_row;
               end else begin
                  ram_waddr = {~bank_ff, data_row};
                  ram_wdata = ram_rdata;
               end
            end else if (final_step) begin
               ram_we    = 1'b1;
               ram_waddr = {~bank_ff, last_row};
               ram_wdata = new_row;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // next-state and register update logic
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bank_in      = bank_ff;
      req_in       = req_ff;
      inside_in    = inside_ff;
      remaining_in = remaining_ff;
      gen_count_in = gen_count_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      row0_in      = row0_ff;
      birth_in     = birth_ff;
      survive_in   = survive_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      // configuration write transaction
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BIRTH_MASK:   birth_in   = csr_data;
            CSR_SURVIVE_MASK: survive_in = csr_data;
            CSR_ROWS_IN_USE:  rows_in    = csr_data[SIZE_W-1:0];
            CSR_COLS_IN_USE:  cols_in    = csr_data[SIZE_W-1:0];
            default:          birth_in   = birth_ff;
         endcase
      end

      unique case (state_ff)
         // sweep the live bank dead after reset
         ST_CLEAR: begin
            step_in = STEP_W'(step_ff + STEP_W'(1));
            if (step_ff[ROW_W-1:0] == ROW_W'(MAX_ROWS - 1)) begin
               step_in  = '0;
               state_in = ST_IDLE;
            end
         end

         // take a command
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               inside_in = (req_data.row <= last_row) && (req_data.col <= last_col);
               unique case (req_data.operation) inside
                  OP_WRITE, OP_READ: begin
                     state_in = ST_CELL;
                  end
                  OP_ADVANCE: begin
                     if (req_data.generation_count == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{read_value: 1'b0, generations_done: gen_count_ff};
                     end else begin
                        remaining_in = req_data.generation_count;
                        step_in      = '0;
                        state_in     = ST_GEN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{read_value: 1'b0, generations_done: gen_count_ff};
                  end
               endcase
            end
         end

         // row data is back: answer a read, the write goes out on the memory port
         ST_CELL: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{read_value: (req_ff.operation == OP_READ) && inside_ff
                                         && ram_rdata[req_ff.col],
                             generations_done: gen_count_ff};
            state_in     = ST_IDLE;
         end

         // one generation per sweep, rows streamed through a three-row window
         ST_GEN: begin
            step_in = STEP_W'(step_ff + STEP_W'(1));
            if (step_ff == STEP_W'(1)) begin
               up_in = ram_rdata;
            end
            if (step_ff == STEP_W'(2)) begin
               row0_in = ram_rdata;
               mid_in  = ram_rdata;
            end
            if (data_step && (data_row <= last_row)) begin
               up_in  = mid_ff;
               mid_in = ram_rdata;
            end
            if (final_step) begin
               step_in      = '0;
               bank_in      = ~bank_ff;
               gen_count_in = GEN_W'(gen_count_ff + GEN_W'(1));
               remaining_in = GEN_W'(remaining_ff - GEN_W'(1));
               if (remaining_ff == GEN_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{read_value: 1'b0,
                                   generations_done: GEN_W'(gen_count_ff + GEN_W'(1))};
                  state_in     = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         bank_ff      <= 1'b0;
         gen_count_ff <= '0;
         birth_ff     <= BIRTH_RESET;
         survive_ff   <= SURVIVE_RESET;
         rows_ff      <= SIZE_RESET;
         cols_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         bank_ff      <= bank_in;
         gen_count_ff <= gen_count_in;
         birth_ff     <= birth_in;
         survive_ff   <= survive_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      inside_ff    <= inside_in;
      remaining_ff <= remaining_in;
      up_ff        <= up_in;
      mid_ff       <= mid_in;
      row0_ff      <= row0_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

>>> tb/tb.sv
// Self-checking testbench for life_like_automaton_generation: cell writes, reads and advances
// are predicted on a private copy of the grid and compared with every rsp_ transaction.
// Depends on lla_pkg and the life_like_automaton_generation RTL only.
module tb;
   import lla_pkg::*;

   // watchdog limit: the sweeps of a full 16-bit advance, taken thrice
   localparam int unsigned STALL_LIMIT = 3 * (MAX_ROWS + 3) * 65536;

   // grid predictor and store of the transactions still due from the block
   class grid_keeper;
      bit [MAX_COLS-1:0] cells  [MAX_ROWS];
      bit [MAX_COLS-1:0] shadow [MAX_ROWS];
      logic [GEN_W-1:0]  gen_total;
      logic [MASK_W-1:0] birth;
      logic [MASK_W-1:0] survive;
      logic [SIZE_W-1:0] rows_reg;
      logic [SIZE_W-1:0] cols_reg;
      rsp_type           replies_due [$];
      int                errors;

      function new();
         for (int r = 0; r < MAX_ROWS; r++) begin
            cells[r]  = '0;
            shadow[r] = '0;
         end
         gen_total = '0;
         birth     = BIRTH_RESET;
         survive   = SURVIVE_RESET;
         rows_reg  = SIZE_RESET;
         cols_reg  = SIZE_RESET;
         errors    = 0;
      endfunction

      // zero acts as one, oversize acts as the maximum
      function int span(logic [SIZE_W-1:0] v, int lim);
         if (v == 0) begin
            return 1;
         end
         return (v > lim) ? lim : int'(v);
      endfunction

      function void set_register(csr_index_type idx, logic [MASK_W-1:0] v);
         case (idx)
            CSR_BIRTH_MASK:   birth    = v;
            CSR_SURVIVE_MASK: survive  = v;
            CSR_ROWS_IN_USE:  rows_reg = v[SIZE_W-1:0];
            CSR_COLS_IN_USE:  cols_reg = v[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      // one generation on the wrapped in-use area, built aside then taken over
      function void evolve_once(int nr, int nc);
         bit [MAX_COLS-1:0] fresh [MAX_ROWS];
         int                colsum [MAX_COLS];
         int                up, dn, lf, rt, cnt;
         bit [MASK_W-1:0]   rule;
         for (int r = 0; r < nr; r++) begin
            up = (r + nr - 1) % nr;
            dn = (r + 1) % nr;
            for (int c = 0; c < nc; c++) begin
               colsum[c] = int'(cells[up][c]) + int'(cells[r][c]) + int'(cells[dn][c]);
            end
            for (int c = 0; c < nc; c++) begin
               lf   = (c + nc - 1) % nc;
               rt   = (c + 1) % nc;
               cnt  = colsum[lf] + colsum[c] + colsum[rt] - int'(cells[r][c]);
               rule = cells[r][c] ? survive : birth;
               fresh[r][c] = rule[cnt];
            end
         end
         for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
               cells[r][c] = fresh[r][c];
            end
         end
      endfunction

      // long runs: once the grid repeats, only the remainder of the period is stepped
      function void run_generations(int unsigned n, int nr, int nc);
         int unsigned since, power;
         bit          found, same;
         if (n == 0) begin
            return;
         end
         since = 0;
         power = 1;
         found = 0;
         for (int r = 0; r < MAX_ROWS; r++) begin
            shadow[r] = cells[r];
         end
         while (n > 0) begin
            evolve_once(nr, nc);
            n--;
            if (!found) begin
               since++;
               same = 1;
               for (int r = 0; r < MAX_ROWS; r++) begin
                  if (shadow[r] != cells[r]) begin
                     same = 0;
                  end
               end
               if (same) begin
                  n     = n % since;
                  found = 1;
               end else if (since == power) begin
                  for (int r = 0; r < MAX_ROWS; r++) begin
                     shadow[r] = cells[r];
                  end
                  power = power << 1;
                  since = 0;
               end
            end
         end
      endfunction

      // accepted command: update the grid and queue the transaction it must produce
      function void take_command(req_type cmd);
         rsp_type want;
         int      nr, nc;
         bit      hit;
         nr  = span(rows_reg, MAX_ROWS);
         nc  = span(cols_reg, MAX_COLS);
         hit = (int'(cmd.row) < nr) && (int'(cmd.col) < nc);
         want.read_value = 1'b0;
         case (cmd.operation)
            OP_WRITE: begin
               if (hit) begin
                  cells[cmd.row][cmd.col] = cmd.cell_value;
               end
            end
            OP_READ: begin
               if (hit) begin
                  want.read_value = cells[cmd.row][cmd.col];
               end
            end
            OP_ADVANCE: begin
               run_generations(cmd.generation_count, nr, nc);
               gen_total = gen_total + cmd.generation_count;
            end
            default: ;
         endcase
         want.generations_done = gen_total;
         replies_due = {replies_due, want};
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (replies_due.size() == 0) begin
            $error("unexpected transaction: read_value %0d generations_done %0d",
                   got.read_value, got.generations_done);
            errors++;
            return;
         end
         want = replies_due.pop_front();
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
            errors++;
         end
         if (got.generations_done !== want.generations_done) begin
            $error("generations_done: expected %0d, actual %0d",
                   want.generations_done, got.generations_done);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   csr_index_type     csr_index;
   logic [MASK_W-1:0] csr_data;

   grid_keeper  keeper = new();
   int unsigned stall_cycles;

   life_like_automaton_generation DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         keeper.check_reply(rsp_data);
      end
   end

   // watchdog on cycles with no transaction of any kind
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("tb: FAIL");
      $finish;
   end

   function automatic req_type cmd_of(op_type op, int r, int c, int v, int g);
      req_type x;
      x.operation        = op;
      x.row              = ROW_W'(r);
      x.col              = COL_W'(c);
      x.cell_value       = v[0];
      x.generation_count = GEN_W'(g);
      return x;
   endfunction

   // present a command and hold it until taken
   task automatic send(req_type cmd);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= cmd;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      keeper.take_command(cmd);
   endtask

   // sender gap after a transaction, now and then a long one
   task automatic sender_gap(int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   endtask

   // stop sending and wait for every transaction due, then let the block settle
   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (keeper.replies_due.size() != 0) begin
         @(posedge clock);
      end
      while (busy) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [MASK_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      keeper.set_register(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(int b, int s, int r, int c);
      write_register(CSR_BIRTH_MASK, MASK_W'(b));
      write_register(CSR_SURVIVE_MASK, MASK_W'(s));
      write_register(CSR_ROWS_IN_USE, MASK_W'(r));
      write_register(CSR_COLS_IN_USE, MASK_W'(c));
   endtask

   // random commands: pattern seeding around a window, reads, advances and some noise
   task automatic run_stage(int count, int idle_pct);
      req_type cmd;
      int      nr, nc, wr, wc, pick, r, c;
      nr = keeper.span(keeper.rows_reg, MAX_ROWS);
      nc = keeper.span(keeper.cols_reg, MAX_COLS);
      wr = 0;
      wc = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            wr = $urandom_range(nr - 1);
            wc = $urandom_range(nc - 1);
         end
         // hold off now and then until the block has caught up
         if ($urandom_range(99) < 3) begin
            @(negedge clock);
            start <= 1'b0;
            while (keeper.replies_due.size() != 0) begin
               @(posedge clock);
            end
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            r = (wr + $urandom_range(7)) % nr;
            c = (wc + $urandom_range(7)) % nc;
         end else if (pick < 90) begin
            r = $urandom_range(nr - 1);
            c = $urandom_range(nc - 1);
         end else begin
            r = $urandom_range(MAX_ROWS - 1);
            c = $urandom_range(MAX_COLS - 1);
         end
         cmd = cmd_of(OP_NOP, r, c, $urandom_range(1), $urandom_range(16'hFFFF));
         pick = $urandom_range(99);
         if (pick < 38) begin
            cmd.operation = OP_WRITE;
         end else if (pick < 75) begin
            cmd.operation = OP_READ;
         end else if (pick < 92) begin
            cmd.operation = OP_ADVANCE;
            cmd.generation_count = ($urandom_range(99) < 85) ? GEN_W'($urandom_range(3))
                                                             : GEN_W'($urandom_range(4, 16));
         end
         send(cmd);
         sender_gap(idle_pct);
      end
   endtask

   // stimulus
   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BIRTH_MASK;
      csr_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full torus with B3/S23: blinker, corner cell, zero and longest advance, no-op
      send(cmd_of(OP_WRITE, 10, 20, 1, 0));
      send(cmd_of(OP_WRITE, 11, 20, 1, 0));
      send(cmd_of(OP_WRITE, 12, 20, 1, 0));
      send(cmd_of(OP_WRITE, 63, 63, 1, 0));
      send(cmd_of(OP_READ, 11, 20, 0, 0));
      send(cmd_of(OP_READ, 0, 0, 0, 0));
      send(cmd_of(OP_ADVANCE, 0, 0, 0, 0));
      send(cmd_of(OP_ADVANCE, 0, 0, 0, 1));
      send(cmd_of(OP_READ, 11, 19, 0, 0));
      send(cmd_of(OP_READ, 63, 63, 0, 0));
      send(cmd_of(OP_NOP, 63, 63, 1, 16'hFFFF));
      send(cmd_of(OP_ADVANCE, 0, 0, 0, 16'hFFFF));
      send(cmd_of(OP_READ, 11, 21, 0, 0));

      // single row (size zero, upper bits beyond the register), oversize columns
      quiesce();
      apply_setting(9'h1FF, 9'h000, 9'h180, 9'd127);
      send(cmd_of(OP_WRITE, 0, 5, 1, 0));
      send(cmd_of(OP_WRITE, 1, 5, 1, 0));
      send(cmd_of(OP_READ, 1, 5, 0, 0));
      send(cmd_of(OP_ADVANCE, 0, 0, 0, 1));
      send(cmd_of(OP_READ, 0, 4, 0, 0));

      // single column, oversize rows
      quiesce();
      apply_setting(9'h155, 9'h0AA, 9'd127, 9'd0);
      send(cmd_of(OP_WRITE, 63, 0, 1, 0));
      send(cmd_of(OP_WRITE, 5, 1, 0, 0));
      send(cmd_of(OP_ADVANCE, 0, 0, 0, 2));
      send(cmd_of(OP_READ, 62, 0, 0, 0));
      send(cmd_of(OP_WRITE, 0, 0, 0, 0));

      // random stages, each with its own rules, sizes and sender idling
      quiesce();
      apply_setting(BIRTH_RESET, SURVIVE_RESET, 9'd64, 9'd64);
      run_stage(540, 0);
      quiesce();
      apply_setting($urandom_range(511), $urandom_range(511),
                    $urandom_range(1, 12), $urandom_range(1, 12));
      run_stage(540, 53);
      quiesce();
      apply_setting($urandom_range(511), $urandom_range(511),
                    $urandom_range(127), $urandom_range(127));
      run_stage(540, 0);
      quiesce();
      apply_setting(9'h048, SURVIVE_RESET, $urandom_range(3, 64), $urandom_range(3, 64));
      run_stage(540, 31);

      // drain
      @(negedge clock);
      start <= 1'b0;
      while (keeper.replies_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (keeper.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/lla_pkg.sv
hdl/lla_grid_ram.sv
hdl/lla_row_update.sv
hdl/life_like_automaton_generation.sv
tb/tb.sv
